[src/edla_pkg.sv]
// Package with the types, constants and divider step shared by the echo level averager.
`timescale 1ns / 1ps

package edla_pkg;

  localparam int unsigned AVG_DEPTH  = 8;
  localparam int unsigned SLOT_W     = $clog2(AVG_DEPTH);
  localparam int unsigned CNT_W      = $clog2(AVG_DEPTH + 1);

  localparam int unsigned HEIGHT_W   = 10;
  localparam int unsigned OFFSET_W   = 8;
  localparam int unsigned CFG_DATA_W = 10;
  localparam int unsigned WIDTH_W    = 16;
  localparam int unsigned DIST_W     = 15;
  localparam int unsigned LEVEL_W    = 14;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned SUM_W      = DIST_W + $clog2(AVG_DEPTH);

  // Distance in q4 centimetres is width * DIST_MUL >> DIST_SHIFT.
  localparam int unsigned DIST_MUL   = 1124;
  localparam int unsigned DIST_SHIFT = 12;
  localparam int unsigned ACC_W      = WIDTH_W + 11;

  localparam int unsigned DVD_W      = 22;
  localparam int unsigned DIVR_W     = 14;
  localparam int unsigned PCT_SCALE  = 100;

  // Cycles of the serial units, two bits per cycle.
  localparam int unsigned MUL_CYC    = WIDTH_W / 2;
  localparam int unsigned AVG_CYC    = (SUM_W + 1) / 2;
  localparam int unsigned PCT_CYC    = DVD_W / 2;
  localparam int unsigned AVG_PAD    = DVD_W - 2 * AVG_CYC;
  localparam int unsigned STEP_W     = 4;

  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 10'd100;
  localparam logic [OFFSET_W-1:0] OFFSET_RST = 8'd5;
  localparam logic [DIST_W-1:0]   AVG_RST    = 15'd800;

  typedef enum logic {
    REG_TANK_HEIGHT   = 1'b0,
    REG_SENSOR_OFFSET = 1'b1
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_CLAMP,
    ST_SUM,
    ST_DIV_AVG,
    ST_AVG,
    ST_LEVEL,
    ST_DIV_PCT,
    ST_DONE
  } edla_state_t;

  typedef struct packed {
    logic [DIVR_W-1:0] rem;
    logic [DVD_W-1:0]  dvd;
  } div_state_t;

  // One restoring division step: the quotient bit shifts into the dividend register.
  function automatic div_state_t div_step(div_state_t s, logic [DIVR_W-1:0] d);
    logic [DIVR_W:0] trial;
    div_state_t      r;
    trial = {s.rem, s.dvd[DVD_W-1]};
    if (trial >= {1'b0, d}) begin
      r.rem = DIVR_W'(trial - {1'b0, d});
      r.dvd = {s.dvd[DVD_W-2:0], 1'b1};
    end else begin
      r.rem = trial[DIVR_W-1:0];
      r.dvd = {s.dvd[DVD_W-2:0], 1'b0};
    end
    return r;
  endfunction

endpackage

[src/echo_distance_level_averager_top.sv]
// Echo width to averaged distance, water level and percent full, with serial multiply and divide.
// The 2-bit serial multiplier and the shared radix-4 restoring divider (used for the average and
// the percent) do the arithmetic; a timeout skips the multiply and the average. Input is taken only
// while the sequencer is idle, so a new request waits until the last result is registered.
// Reset: synchronous, active low; height 100 cm, offset 5 cm, empty window, average 50 cm.
`timescale 1ns / 1ps

module echo_distance_level_averager_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic                             cfg_index,
  input  logic [edla_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [edla_pkg::WIDTH_W-1:0]     in_echo_width_us,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [edla_pkg::DIST_W-1:0]      out_distance_q4,
  output logic [edla_pkg::LEVEL_W-1:0]     out_level_q4,
  output logic [edla_pkg::PCT_W-1:0]       out_fill_percent,
  output logic                             out_timed_out
);
  import edla_pkg::*;

  edla_state_t          state_r, state_nxt;
  logic [HEIGHT_W-1:0]  height_r;
  logic [OFFSET_W-1:0]  offset_r;
  logic [WIDTH_W-1:0]   width_r, width_nxt;
  logic [ACC_W-1:0]     acc_r, acc_nxt;
  logic [STEP_W-1:0]    cnt_r, cnt_nxt;
  logic [DIST_W-1:0]    dist_r, dist_nxt;
  logic [DIST_W-1:0]    old_r;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [SLOT_W-1:0]    slot_r, slot_nxt;
  logic                 full_r, full_nxt;
  logic [DIVR_W-1:0]    div_r, div_nxt;
  logic [DVD_W-1:0]     dvd_r, dvd_nxt;
  logic [DIVR_W-1:0]    rem_r, rem_nxt;
  logic [DIST_W-1:0]    avg_r, avg_nxt;
  logic [LEVEL_W-1:0]   lvl_r, lvl_nxt;
  logic                 timed_r, timed_nxt;
  logic                 out_valid_r, out_valid_nxt;
  logic [DIST_W-1:0]    out_dist_r, out_dist_nxt;
  logic [LEVEL_W-1:0]   out_level_r, out_level_nxt;
  logic [PCT_W-1:0]     out_pct_r, out_pct_nxt;
  logic                 out_timed_r, out_timed_nxt;

  logic [DIST_W-1:0]    window_mem [AVG_DEPTH];

  logic [DIST_W-1:0]    top_q4;
  logic [LEVEL_W-1:0]   cap_q4;
  logic [DIST_W-1:0]    raw_dist;
  logic [ACC_W-1:0]     mul_term;
  logic [DVD_W-1:0]     lvl_x100;
  logic [LEVEL_W-1:0]   lvl_calc;
  logic [CNT_W-1:0]     fill_cnt;
  div_state_t           div_a, div_b;

  assign top_q4   = {DIST_W'(HEIGHT_W'(0) + {1'b0, height_r} + {3'b000, offset_r})} << 4;
  assign cap_q4   = {height_r, 4'b0000};
  assign raw_dist = acc_r[DIST_SHIFT +: DIST_W];
  assign mul_term = (width_r[WIDTH_W-1] ? ACC_W'(DIST_MUL << 1) : ACC_W'(0))
                  + (width_r[WIDTH_W-2] ? ACC_W'(DIST_MUL) : ACC_W'(0));
  assign lvl_x100 = (DVD_W'(lvl_calc) << 6) + (DVD_W'(lvl_calc) << 5) + (DVD_W'(lvl_calc) << 2);
  assign div_a    = div_step('{rem: rem_r, dvd: dvd_r}, div_r);
  assign div_b    = div_step(div_a, div_r);

  always_comb begin
    if (avg_r >= top_q4) begin
      lvl_calc = '0;
    end else if ((top_q4 - avg_r) > DIST_W'(cap_q4)) begin
      lvl_calc = cap_q4;
    end else begin
      lvl_calc = LEVEL_W'(top_q4 - avg_r);
    end
  end

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_distance_q4  = out_dist_r;
  assign out_level_q4     = out_level_r;
  assign out_fill_percent = out_pct_r;
  assign out_timed_out    = out_timed_r;

  always_comb begin
    state_nxt     = state_r;
    width_nxt     = width_r;
    acc_nxt       = acc_r;
    cnt_nxt       = cnt_r;
    dist_nxt      = dist_r;
    sum_nxt       = sum_r;
    slot_nxt      = slot_r;
    full_nxt      = full_r;
    div_nxt       = div_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    avg_nxt       = avg_r;
    lvl_nxt       = lvl_r;
    timed_nxt     = timed_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_dist_nxt  = out_dist_r;
    out_level_nxt = out_level_r;
    out_pct_nxt   = out_pct_r;
    out_timed_nxt = out_timed_r;
    fill_cnt      = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          width_nxt = in_echo_width_us;
          acc_nxt   = '0;
          cnt_nxt   = STEP_W'(MUL_CYC - 1);
          timed_nxt = (in_echo_width_us == '0);
          // A timeout leaves the window alone and reports from the held average.
          state_nxt = (in_echo_width_us == '0) ? ST_LEVEL : ST_MUL;
        end
      end
      ST_MUL: begin
        acc_nxt   = (acc_r << 2) + mul_term;
        width_nxt = width_r << 2;
        cnt_nxt   = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_CLAMP;
        end
      end
      ST_CLAMP: begin
        dist_nxt  = (raw_dist > top_q4) ? top_q4 : raw_dist;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        sum_nxt = sum_r - (full_r ? SUM_W'(old_r) : SUM_W'(0)) + SUM_W'(dist_r);
        if (slot_r == SLOT_W'(AVG_DEPTH - 1)) begin
          slot_nxt = '0;
          full_nxt = 1'b1;
        end else begin
          slot_nxt = slot_r + 1'b1;
        end
        fill_cnt  = full_nxt ? CNT_W'(AVG_DEPTH) : CNT_W'(slot_nxt);
        div_nxt   = DIVR_W'(fill_cnt);
        dvd_nxt   = DVD_W'(sum_nxt) << AVG_PAD;
        rem_nxt   = '0;
        cnt_nxt   = STEP_W'(AVG_CYC - 1);
        state_nxt = ST_DIV_AVG;
      end
      ST_DIV_AVG: begin
        dvd_nxt = div_b.dvd;
        rem_nxt = div_b.rem;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_AVG;
        end
      end
      ST_AVG: begin
        avg_nxt   = dvd_r[DIST_W-1:0];
        state_nxt = ST_LEVEL;
      end
      ST_LEVEL: begin
        lvl_nxt   = lvl_calc;
        dvd_nxt   = lvl_x100;
        rem_nxt   = '0;
        div_nxt   = cap_q4;
        cnt_nxt   = STEP_W'(PCT_CYC - 1);
        state_nxt = (height_r == '0) ? ST_DONE : ST_DIV_PCT;
      end
      ST_DIV_PCT: begin
        dvd_nxt = div_b.dvd;
        rem_nxt = div_b.rem;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_dist_nxt  = avg_r;
          out_level_nxt = lvl_r;
          out_timed_nxt = timed_r;
          if (height_r == '0) begin
            out_pct_nxt = '0;
          end else if (dvd_r > DVD_W'(PCT_SCALE)) begin
            out_pct_nxt = PCT_W'(PCT_SCALE);
          end else begin
            out_pct_nxt = dvd_r[PCT_W-1:0];
          end
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      height_r    <= HEIGHT_RST;
      offset_r    <= OFFSET_RST;
      sum_r       <= '0;
      slot_r      <= '0;
      full_r      <= 1'b0;
      avg_r       <= AVG_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      sum_r       <= sum_nxt;
      slot_r      <= slot_nxt;
      full_r      <= full_nxt;
      avg_r       <= avg_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_TANK_HEIGHT:   height_r <= cfg_data[HEIGHT_W-1:0];
          REG_SENSOR_OFFSET: offset_r <= cfg_data[OFFSET_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    width_r     <= width_nxt;
    acc_r       <= acc_nxt;
    cnt_r       <= cnt_nxt;
    dist_r      <= dist_nxt;
    div_r       <= div_nxt;
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    lvl_r       <= lvl_nxt;
    timed_r     <= timed_nxt;
    out_dist_r  <= out_dist_nxt;
    out_level_r <= out_level_nxt;
    out_pct_r   <= out_pct_nxt;
    out_timed_r <= out_timed_nxt;
  end

  // Window storage: the old sample is read in the cycle before the new one overwrites it.
  always_ff @(posedge clk) begin
    if (state_r == ST_CLAMP) begin
      old_r <= window_mem[slot_r];
    end
    if (state_r == ST_SUM) begin
      window_mem[slot_r] <= dist_r;
    end
  end

  a_avg_divisor_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_AVG) |-> (div_r != '0))
    else $error("average divisor is zero");

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV_AVG || state_r == ST_DIV_PCT) |-> (rem_r < div_r))
    else $error("divider remainder out of range");

  a_timeout_skips_window: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall && in_echo_width_us == '0) |=>
      (state_r == ST_LEVEL && $stable(sum_r) && $stable(slot_r)))
    else $error("timeout request touched the window");

  a_level_within_cap: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DONE) |-> (lvl_r <= cap_q4))
    else $error("level above tank height");

endmodule

[test/echo_distance_level_averager_checker.sv]
// Checker for the echo level averager: predicts each reading and compares accepted results.
`timescale 1ns / 1ps

module echo_distance_level_averager_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_wr_en,
  input  logic                            cfg_index,
  input  logic [edla_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  input  logic                            in_stall,
  input  logic [edla_pkg::WIDTH_W-1:0]    in_echo_width_us,
  input  logic                            out_valid,
  input  logic                            out_stall,
  input  logic [edla_pkg::DIST_W-1:0]     out_distance_q4,
  input  logic [edla_pkg::LEVEL_W-1:0]    out_level_q4,
  input  logic [edla_pkg::PCT_W-1:0]      out_fill_percent,
  input  logic                            out_timed_out,
  output int unsigned                     fail_count,
  output int unsigned                     pending,
  output int unsigned                     readings_checked
);
  import edla_pkg::*;

  typedef struct packed {
    logic [DIST_W-1:0]  dist_q4;
    logic [LEVEL_W-1:0] level_q4;
    logic [PCT_W-1:0]   percent;
    logic               timed_out;
  } gauge_reading_t;

  // Shadow copy of the gauge state and registers.
  logic [HEIGHT_W-1:0] height_cm;
  logic [OFFSET_W-1:0] offset_cm;
  logic [DIST_W-1:0]   window_q4 [AVG_DEPTH];
  logic [SLOT_W-1:0]   next_slot;
  logic                wrapped;
  logic [SUM_W-1:0]    window_total;
  logic [DIST_W-1:0]   avg_q4;

  gauge_reading_t readings_due[$];
  gauge_reading_t want;

  initial begin
    fail_count       = 0;
    pending          = 0;
    readings_checked = 0;
  end

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned wanted);
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, wanted);
    fail_count++;
  endtask

  function automatic gauge_reading_t predict_reading(input logic [WIDTH_W-1:0] width_us);
    int unsigned    top_q4;
    int unsigned    cap_q4;
    int unsigned    sample_q4;
    int unsigned    count;
    int unsigned    lvl;
    gauge_reading_t r;
    top_q4 = (32'(height_cm) + 32'(offset_cm)) * 16;
    cap_q4 = 32'(height_cm) * 16;
    if (width_us != '0) begin
      sample_q4 = (32'(width_us) * DIST_MUL) >> DIST_SHIFT;
      if (sample_q4 > top_q4) sample_q4 = top_q4;
      // Once the ring has wrapped, the oldest sample drops out of the sum.
      if (wrapped) window_total = window_total - SUM_W'(window_q4[next_slot]);
      window_q4[next_slot] = DIST_W'(sample_q4);
      window_total = window_total + SUM_W'(sample_q4);
      if (32'(next_slot) == AVG_DEPTH - 1) begin
        next_slot = '0;
        wrapped   = 1'b1;
      end else begin
        next_slot = next_slot + 1'b1;
      end
      count = wrapped ? AVG_DEPTH : 32'(next_slot);
      if (count == 0) count = 1;
      avg_q4 = DIST_W'(32'(window_total) / count);
    end
    lvl = (32'(avg_q4) >= top_q4) ? 0 : top_q4 - 32'(avg_q4);
    if (lvl > cap_q4) lvl = cap_q4;
    r.dist_q4   = avg_q4;
    r.level_q4  = LEVEL_W'(lvl);
    r.timed_out = (width_us == '0);
    if (height_cm == '0) begin
      r.percent = '0;
    end else begin
      r.percent = PCT_W'(((lvl * 100) / cap_q4 > 100) ? 100 : (lvl * 100) / cap_q4);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      height_cm    = HEIGHT_RST;
      offset_cm    = OFFSET_RST;
      next_slot    = '0;
      wrapped      = 1'b0;
      window_total = '0;
      avg_q4       = AVG_RST;
      for (int i = 0; i < AVG_DEPTH; i++) window_q4[i] = '0;
      readings_due.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_index))
          REG_TANK_HEIGHT:   height_cm = cfg_data[HEIGHT_W-1:0];
          REG_SENSOR_OFFSET: offset_cm = cfg_data[OFFSET_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) readings_due.push_back(predict_reading(in_echo_width_us));
      if (out_valid && !out_stall) begin
        if (readings_due.size() == 0) begin
          report_mismatch("result with no request outstanding", out_distance_q4, 0);
        end else begin
          want = readings_due.pop_front();
          readings_checked++;
          if (out_distance_q4 !== want.dist_q4)
            report_mismatch("distance_q4", out_distance_q4, want.dist_q4);
          if (out_level_q4 !== want.level_q4)
            report_mismatch("level_q4", out_level_q4, want.level_q4);
          if (out_fill_percent !== want.percent)
            report_mismatch("fill_percent", out_fill_percent, want.percent);
          if (out_timed_out !== want.timed_out)
            report_mismatch("timed_out", out_timed_out, want.timed_out);
        end
      end
    end
    pending = readings_due.size();
  end

endmodule

[test/echo_distance_level_averager_top_tb.sv]
// Testbench top for the echo level averager: stimulus, register settings, idling and verdict.
`timescale 1ns / 1ps

module echo_distance_level_averager_top_tb;
  import edla_pkg::*;

  localparam int unsigned NUM_SETTINGS = 13;
  localparam int unsigned RANDOM_PER_SETTING = 106;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_wr_en;
  cfg_reg_t              cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_stall;
  logic [WIDTH_W-1:0]    in_echo_width_us;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [DIST_W-1:0]     out_distance_q4;
  logic [LEVEL_W-1:0]    out_level_q4;
  logic [PCT_W-1:0]      out_fill_percent;
  logic                  out_timed_out;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned readings_checked;

  int unsigned idle_pct = 0;
  int unsigned stall_pct = 0;
  bit          hold_request = 1'b0;
  int unsigned hold_left = 0;
  int unsigned widths_sent = 0;
  int unsigned timeouts_sent = 0;

  // Tank heights and sensor offsets visited in turn, extremes first.
  int unsigned setting_height [NUM_SETTINGS] =
    '{0, 1023, 0, 1023, 1, 100, 200, 512, 37, 1000, 3, 750, 60};
  int unsigned setting_offset [NUM_SETTINGS] =
    '{0, 255, 255, 0, 1, 5, 10, 128, 200, 17, 0, 64, 2};

  always #6 clk = ~clk;

  echo_distance_level_averager_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_echo_width_us (in_echo_width_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_distance_q4  (out_distance_q4),
    .out_level_q4     (out_level_q4),
    .out_fill_percent (out_fill_percent),
    .out_timed_out    (out_timed_out)
  );

  echo_distance_level_averager_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_echo_width_us (in_echo_width_us),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_distance_q4  (out_distance_q4),
    .out_level_q4     (out_level_q4),
    .out_fill_percent (out_fill_percent),
    .out_timed_out    (out_timed_out),
    .fail_count       (fail_count),
    .pending          (pending),
    .readings_checked (readings_checked)
  );

  // Result side: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Called just after a rising edge; returns at the edge where the request is taken.
  task automatic send_echo(input logic [WIDTH_W-1:0] width_us);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_echo_width_us <= width_us;
    forever begin
      @(negedge clk);
      if (!in_stall) break;
    end
    @(posedge clk);
    widths_sent++;
    if (width_us == '0) timeouts_sent++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pending != 0);
  endtask

  task automatic set_levels(input int unsigned height, input int unsigned offset);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_TANK_HEIGHT;
    cfg_data  <= CFG_DATA_W'(height);
    @(posedge clk);
    cfg_index <= REG_SENSOR_OFFSET;
    cfg_data  <= CFG_DATA_W'(offset);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Mostly widths that land inside the tank, plus timeouts and full-range values.
  function automatic logic [WIDTH_W-1:0] pick_width(input int unsigned height,
                                                    input int unsigned offset);
    int unsigned pick;
    int unsigned span;
    pick = $urandom_range(99);
    span = ((height + offset) * 16 * 4096) / DIST_MUL + 200;
    if (span > 65535) span = 65535;
    if (pick < 8) return '0;
    if (pick < 70) return WIDTH_W'($urandom_range(span, 1));
    if (pick < 85) return WIDTH_W'($urandom_range(65535, 1));
    return WIDTH_W'($urandom);
  endfunction

  initial begin
    logic [WIDTH_W-1:0] opening [14] = '{16'd0, 16'd1, 16'd2, 16'hFFFF, 16'd0, 16'd3644,
                                        16'd5000, 16'hAAAA, 16'h5555, 16'd0, 16'd6000,
                                        16'd7000, 16'd100, 16'd0};
    rst_n            = 1'b0;
    cfg_wr_en        = 1'b0;
    cfg_index        = REG_TANK_HEIGHT;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_echo_width_us = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: a timeout before any sample, the clamp, and a window that wraps.
    foreach (opening[i]) send_echo(opening[i]);
    in_valid <= 1'b0;
    wait_drained();

    for (int s = 0; s < NUM_SETTINGS; s++) begin
      set_levels(setting_height[s], setting_offset[s]);
      case (s % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 60; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 60; end
        default: begin idle_pct = 29; stall_pct = 29; end
      endcase
      // With the sender busy, a long hold on the result side backs up the input.
      if (s == 4) hold_request = 1'b1;
      send_echo('0);
      send_echo(16'hFFFF);
      for (int n = 0; n < RANDOM_PER_SETTING; n++)
        send_echo(pick_width(setting_height[s], setting_offset[s]));
      in_valid <= 1'b0;
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d echo widths (%0d timeouts) over %0d register settings; %0d readings checked.",
             widths_sent, timeouts_sent, NUM_SETTINGS + 1, readings_checked);
    $display("Idling covered none, sender-only, receiver-only and both, plus a long result hold.");
    if (fail_count == 0) begin
      $display("echo_distance_level_averager_top_tb: clean");
    end else begin
      $display("echo_distance_level_averager_top_tb: errors");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("Run did not finish in time; %0d readings still outstanding.", pending);
    $display("echo_distance_level_averager_top_tb: errors");
    $finish;
  end

endmodule

[echo_distance_level_averager_top.f]
src/edla_pkg.sv
src/echo_distance_level_averager_top.sv
test/echo_distance_level_averager_checker.sv
test/echo_distance_level_averager_top_tb.sv
